@@ sv/slt_pkg.sv @@
// Package for the sorted list table: sizes, operation and status codes, control structs.
// No dependencies.
package slt_pkg;
    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        FUNC_INSERT  = 3'd0,
        FUNC_REM_MIN = 3'd1,
        FUNC_REM_MAX = 3'd2,
        FUNC_REM_VAL = 3'd3,
        FUNC_SEARCH  = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the operation
        logic execute;   // apply the captured operation to the cell row
        logic release_q; // result register has been transferred
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic result_valid;
    } t_stat;
endpackage

@@ sv/slt_if.sv @@
// Valid/ready channel interfaces for the sorted list table.
// Depends on slt_pkg.
interface slt_in_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        func;
    logic signed [slt_pkg::VALUE_WIDTH-1:0] value;
    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

interface slt_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic signed [slt_pkg::VALUE_WIDTH-1:0] removed_value;
    logic [3:0]                        found_index;
    logic [4:0]                        match_count;
    logic [4:0]                        occupancy;
    modport source (output valid, status, removed_value, found_index, match_count,
                    occupancy, input ready);
    modport sink   (input valid, status, removed_value, found_index, match_count,
                    occupancy, output ready);
endinterface

@@ sv/slt_ctrl.sv @@
// Controller of the sorted list table: sequences capture, execute and result hold.
// Depends on slt_pkg.
module slt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    input  slt_pkg::t_stat i_stat,
    output slt_pkg::t_cmd  o_cmd
);
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    // Accept while idle and the result register is free or leaving this cycle.
    logic w_out_free;
    assign w_out_free = !i_stat.result_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;

    always_comb begin
        o_cmd.load      = 1'b0;
        o_cmd.execute   = 1'b0;
        o_cmd.release_q = i_stat.result_valid && i_out_ready;
        n_state         = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    o_cmd.execute = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

@@ sv/slt_datapath.sv @@
// Datapath of the sorted list table: a row of compare-and-shift cells and the result register.
// Depends on slt_pkg.
module slt_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  slt_pkg::t_cmd                          i_cmd,
    output slt_pkg::t_stat                         o_stat,
    input  logic [2:0]                             i_func,
    input  logic signed [slt_pkg::VALUE_WIDTH-1:0] i_value,
    output logic [1:0]                             o_status,
    output logic signed [slt_pkg::VALUE_WIDTH-1:0] o_removed_value,
    output logic [3:0]                             o_found_index,
    output logic [4:0]                             o_match_count,
    output logic [4:0]                             o_occupancy
);
    localparam int D  = slt_pkg::DEPTH;
    localparam int W  = slt_pkg::VALUE_WIDTH;
    localparam int IW = slt_pkg::IDX_W;
    localparam int CW = slt_pkg::CNT_W;

    // Captured operation.
    logic [2:0]          r_func;
    logic signed [W-1:0] r_value;

    // Cell row and fill count.
    logic signed [W-1:0] r_cell [D];
    logic [CW-1:0]       r_fill;

    // Result register.
    logic                r_res_valid;
    logic [1:0]          r_status;
    logic signed [W-1:0] r_removed;
    logic [3:0]          r_found;
    logic [4:0]          r_matches;
    logic [4:0]          r_occ;

    // Per-cell flags: occupied, less than the operand, equal to it.
    logic [D-1:0] w_occ, w_lt, w_eq, w_eq_first, w_lt_pre;
    always_comb begin
        for (int i = 0; i < D; i++) begin
            w_occ[i] = CW'(i) < r_fill;
            w_lt[i]  = w_occ[i] && (r_cell[i] < r_value);
            w_eq[i]  = w_occ[i] && (r_cell[i] == r_value);
        end
        // First match: equal with no equal cell below (sorted row, so a prefix test).
        w_eq_first = w_eq & ~(w_eq << 1);
        // Cells before the insert point: occupied and less than the operand.
        w_lt_pre   = w_lt;
    end

    // Match count and first-match index, counted over the cell row.
    logic [CW-1:0] w_cnt;
    logic [IW-1:0] w_first;
    always_comb begin
        w_cnt   = '0;
        w_first = '0;
        for (int i = 0; i < D; i++) begin
            w_cnt = w_cnt + CW'(w_eq[i]);
            if (w_eq_first[i]) w_first = IW'(i);
        end
    end

    logic w_empty, w_full, w_found;
    assign w_empty = (r_fill == '0);
    assign w_full  = (r_fill == CW'(D));
    assign w_found = |w_eq;

    // Removal point for each remove operation.
    logic [IW-1:0] w_rm_pos;
    always_comb begin
        case (r_func)
            slt_pkg::FUNC_REM_MIN: w_rm_pos = '0;
            slt_pkg::FUNC_REM_MAX: w_rm_pos = IW'(r_fill - CW'(1));
            default:               w_rm_pos = w_first;
        endcase
    end

    logic w_do_ins, w_do_rm;
    always_comb begin
        w_do_ins = (r_func == slt_pkg::FUNC_INSERT) && !w_full;
        w_do_rm  = ((r_func == slt_pkg::FUNC_REM_MIN) || (r_func == slt_pkg::FUNC_REM_MAX))
                   && !w_empty
                   || (r_func == slt_pkg::FUNC_REM_VAL) && w_found;
    end

    // Cell update: each cell keeps, takes the operand, or takes a neighbor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            for (int i = 0; i < D; i++) begin
                if (w_do_ins) begin
                    if (!w_lt_pre[i]) begin
                        if (i == 0 || w_lt_pre[(i == 0) ? 0 : i-1]) r_cell[i] <= r_value;
                        else r_cell[i] <= r_cell[(i == 0) ? 0 : i-1];
                    end
                end else if (w_do_rm) begin
                    if (IW'(i) >= w_rm_pos && i < D-1) r_cell[i] <= r_cell[(i < D-1) ? i+1 : i];
                end
            end
        end
    end

    // Fill count, result register and captured operation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cmd.release_q) r_res_valid <= 1'b0;
            if (i_cmd.execute) begin
                r_res_valid <= 1'b1;
                if (w_do_ins) r_fill <= r_fill + CW'(1);
                else if (w_do_rm) r_fill <= r_fill - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
        if (i_cmd.execute) begin
            r_status  <= slt_pkg::ST_OK;
            r_removed <= '0;
            r_found   <= '0;
            r_matches <= '0;
            r_occ     <= 5'(r_fill);
            case (r_func)
                slt_pkg::FUNC_INSERT: begin
                    if (w_full) r_status <= slt_pkg::ST_FULL;
                    else r_occ <= 5'(r_fill + CW'(1));
                end
                slt_pkg::FUNC_REM_MIN, slt_pkg::FUNC_REM_MAX, slt_pkg::FUNC_REM_VAL: begin
                    if (w_empty) r_status <= slt_pkg::ST_EMPTY;
                    else if (!w_do_rm) r_status <= slt_pkg::ST_NOT_FOUND;
                    else begin
                        r_removed <= r_cell[w_rm_pos];
                        r_occ     <= 5'(r_fill - CW'(1));
                    end
                end
                slt_pkg::FUNC_SEARCH: begin
                    if (w_empty) r_status <= slt_pkg::ST_EMPTY;
                    else if (!w_found) r_status <= slt_pkg::ST_NOT_FOUND;
                    else begin
                        r_found   <= 4'(w_first);
                        r_matches <= 5'(w_cnt);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat.result_valid = r_res_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_found_index   = r_found;
    assign o_match_count   = r_matches;
    assign o_occupancy     = r_occ;
endmodule

@@ sv/sorted_list_table.sv @@
// Top level of the sorted list table: controller, cell-row datapath and channel hookup.
// Depends on slt_pkg, slt_if, slt_ctrl and slt_datapath.
//
// Usage: the input channel carries one operation (func, value) per transfer:
// insert, remove smallest, remove largest, remove by value, or search.
// The output channel carries one result per operation: status, removed
// value, first-match index, match count and the occupancy afterwards.
// The table holds up to DEPTH values in ascending order in a row of
// compare-and-shift cells; every cell compares against the operand in
// parallel and shifts by one place in a single update.
// A result is registered in the cycle after the input transfer: the
// controller captures the operation, then applies it in S_EXEC.
// The block takes no new operation until the captured one has been
// applied to the cell row and the result register is free or leaving.
// Reset empties the table at once (fill count zero) and drops any result.
// When the receiver stalls, the result register holds its value and the
// block stops taking new operations until the result has been transferred.
module sorted_list_table (
    input logic i_clk,
    input logic i_rst_n,
    slt_in_if.sink    in_ch,
    slt_out_if.source out_ch
);
    slt_pkg::t_cmd  w_cmd;
    slt_pkg::t_stat w_stat;

    slt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .i_out_ready (out_ch.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    slt_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_func          (in_ch.func),
        .i_value         (in_ch.value),
        .o_status        (out_ch.status),
        .o_removed_value (out_ch.removed_value),
        .o_found_index   (out_ch.found_index),
        .o_match_count   (out_ch.match_count),
        .o_occupancy     (out_ch.occupancy)
    );

    assign out_ch.valid = w_stat.result_valid;

    // No new operation is taken while a result waits and the receiver stalls.
    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
        else $error("input taken while a result is stalled");

    // Every accepted operation yields a valid result once the controller has passed S_EXEC.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ch.valid && in_ch.ready) |=> ##1 out_ch.valid)
        else $error("missing result after transfer");

    // Occupancy never exceeds the table depth.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (out_ch.occupancy <= 5'(slt_pkg::DEPTH)))
        else $error("occupancy above depth");
endmodule

@@ bench/tb_sorted_list_table.sv @@
// Self-checking bench for the sorted list table: random and directed operations
// through the valid/ready channels, checked against an in-bench sorted-table predictor.
// Depends on slt_pkg, slt_if and sorted_list_table.
module tb_sorted_list_table;
    timeunit 1ns;
    timeprecision 1ps;
    import slt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [2:0]                    func;
        logic signed [VALUE_WIDTH-1:0] value;
    } t_op;

    typedef struct {
        logic [1:0]                    status;
        logic signed [VALUE_WIDTH-1:0] removed_value;
        logic [3:0]                    found_index;
        logic [4:0]                    match_count;
        logic [4:0]                    occupancy;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    slt_in_if  in_ch();
    slt_out_if out_ch();

    sorted_list_table DUT (.i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch));

    always #4 i_clk = ~i_clk;

    t_op  pending_ops[$];
    t_res expected_results[$];
    logic signed [VALUE_WIDTH-1:0] table_model[$];
    int   mismatch_count = 0;
    int   idle_cycles = 0;
    bit   stimulus_done = 0;
    bit   hold_off = 0;
    bit   timed_out = 0;
    int   burst_left = 0;
    int   gap_left = 0;

    // Predict the result of one operation and update the model table.
    function automatic t_res predict_sorted_op(t_op op);
        t_res r;
        int   pos;
        int   n;
        r = '{ST_OK, '0, '0, '0, '0};
        n = table_model.size();
        case (op.func)
            FUNC_INSERT: begin
                if (n >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < n && table_model[pos] < op.value) pos++;
                    table_model.insert(pos, op.value);
                end
            end
            FUNC_REM_MIN, FUNC_REM_MAX: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else if (op.func == FUNC_REM_MIN) begin
                    r.removed_value = table_model.pop_front();
                end else begin
                    r.removed_value = table_model.pop_back();
                end
            end
            FUNC_REM_VAL: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < n && table_model[pos] != op.value) pos++;
                    if (pos == n) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.removed_value = table_model[pos];
                        table_model.delete(pos);
                    end
                end
            end
            FUNC_SEARCH: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = n - 1; i >= 0; i--) begin
                        if (table_model[i] == op.value) begin
                            r.found_index = 4'(i);
                            r.match_count++;
                        end
                    end
                    if (r.match_count == 0) r.status = ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
        r.occupancy = 5'(table_model.size());
        return r;
    endfunction

    // Values drawn from a small pool so searches and removals often hit.
    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'sh7FFFFFFF;
            2: return 32'sh80000000;
            default: return $signed(32'($urandom_range(0, 12))) - 6;
        endcase
    endfunction

    function automatic t_op make_op(int f, logic signed [VALUE_WIDTH-1:0] v);
        t_op op;
        op.func  = f[2:0];
        op.value = v;
        return op;
    endfunction

    // Driver: sends queued operations in bursts separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.func  <= '0;
            in_ch.value <= '0;
        end else begin
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    in_ch.valid <= 1'b1;
                    in_ch.func  <= pending_ops[0].func;
                    in_ch.value <= pending_ops[0].value;
                    void'(pending_ops.pop_front());
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Expected results are computed at the input transfer, ahead of the output.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            expected_results.push_back(predict_sorted_op(make_op(in_ch.func, in_ch.value)));
        end
    end

    // Receiver stall pattern with an optional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_off) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 9) < 7);
        end
    end

    // Monitor: compare each output transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("Unexpected result transfer");
            end else begin
                exp_r = expected_results.pop_front();
                if (out_ch.status !== exp_r.status
                        || out_ch.removed_value !== exp_r.removed_value
                        || out_ch.found_index !== exp_r.found_index
                        || out_ch.match_count !== exp_r.match_count
                        || out_ch.occupancy !== exp_r.occupancy) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch: exp st=%0d rm=%0d idx=%0d cnt=%0d occ=%0d",
                                 exp_r.status, exp_r.removed_value, exp_r.found_index,
                                 exp_r.match_count, exp_r.occupancy);
                        $display("          got st=%0d rm=%0d idx=%0d cnt=%0d occ=%0d",
                                 out_ch.status, out_ch.removed_value, out_ch.found_index,
                                 out_ch.match_count, out_ch.occupancy);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles without any transfer.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || stimulus_done) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (timed_out) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus: directed cases first, then a random mix.
    initial begin
        // Directed part: empty cases, extremes, duplicates, unused function codes, fill to full.
        pending_ops.push_back(make_op(FUNC_REM_MIN, 0));
        pending_ops.push_back(make_op(FUNC_REM_MAX, 0));
        pending_ops.push_back(make_op(FUNC_REM_VAL, 5));
        pending_ops.push_back(make_op(FUNC_SEARCH, 5));
        pending_ops.push_back(make_op(7, -1));
        pending_ops.push_back(make_op(FUNC_INSERT, 32'sh7FFFFFFF));
        pending_ops.push_back(make_op(FUNC_INSERT, 32'sh80000000));
        pending_ops.push_back(make_op(FUNC_INSERT, 3));
        pending_ops.push_back(make_op(FUNC_INSERT, 3));
        pending_ops.push_back(make_op(FUNC_SEARCH, 3));
        pending_ops.push_back(make_op(FUNC_SEARCH, 4));
        pending_ops.push_back(make_op(FUNC_REM_VAL, 4));
        pending_ops.push_back(make_op(FUNC_REM_VAL, 3));
        pending_ops.push_back(make_op(5, 0));
        pending_ops.push_back(make_op(6, 0));
        for (int i = 0; i < 15; i++) pending_ops.push_back(make_op(FUNC_INSERT, 0));
        pending_ops.push_back(make_op(FUNC_INSERT, -7));
        pending_ops.push_back(make_op(FUNC_SEARCH, 0));
        pending_ops.push_back(make_op(FUNC_REM_MAX, 0));
        pending_ops.push_back(make_op(FUNC_REM_MIN, 0));
        // Random part, insert-biased or remove-biased in phases so the
        // table swings between empty and full.
        for (int i = 0; i < 1100; i++) begin
            int bias;
            int f;
            bias = ((i / 150) % 2 == 0) ? 6 : 2;
            if ($urandom_range(0, 9) < bias) f = FUNC_INSERT;
            else f = $urandom_range(1, 7);
            pending_ops.push_back(make_op(f, pick_value()));
        end
    end

    // Reset, long receiver hold-off, and end of run.
    initial begin
        in_ch.valid  = 1'b0;
        in_ch.func   = '0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off <= 1'b0;
        wait (pending_ops.size() == 0 && !in_ch.valid);
        wait (expected_results.size() == 0);
        stimulus_done = 1;
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
